FILE: rtl/core/jsv_pkg.sv
package jsv_pkg;

    // Parser states, one per position in the JSON grammar
    typedef enum logic [4:0] {
        G_TOP, G_VALUE, G_ARR_FIRST, G_OBJ_FIRST, G_OBJ_KEY, G_COLON, G_AFTER,
        G_STR, G_STR_ESC, G_STR_HEX, G_KEY, G_KEY_ESC, G_KEY_HEX,
        G_LIT_T, G_LIT_F, G_LIT_N,
        G_NUM_MINUS, G_NUM_ZERO, G_NUM_INT, G_NUM_DOT, G_NUM_FRAC,
        G_NUM_E, G_NUM_ESIGN, G_NUM_EXP
    } gstate_t;

    typedef enum logic [1:0] {
        VERDICT_BUSY   = 2'd0,
        VERDICT_ACCEPT = 2'd1,
        VERDICT_REJECT = 2'd2
    } verdict_t;

    localparam logic KIND_ARRAY  = 1'b0;
    localparam logic KIND_OBJECT = 1'b1;

    localparam logic [6:0] MAX_DEPTH_RESET = 7'd64;
    localparam logic [2:0] HEX_DIGITS      = 3'd4;
    localparam logic [2:0] LEN_TRUE        = 3'd4;
    localparam logic [2:0] LEN_FALSE       = 3'd5;
    localparam logic [2:0] LEN_NULL        = 3'd4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_simple_escape(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == "b" ||
               c == "f" || c == "n" || c == "r" || c == "t";
    endfunction

    // Expected byte at position p of a literal word; zero beyond the end
    function automatic logic [7:0] lit_char(input gstate_t st, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (st)
            G_LIT_T: begin
                unique case (p)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            G_LIT_F: begin
                unique case (p)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            G_LIT_N: begin
                unique case (p)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input gstate_t st);
        logic [2:0] n;
        unique case (st)
            G_LIT_F: n = LEN_FALSE;
            G_LIT_N: n = LEN_NULL;
            default: n = LEN_TRUE;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/json_syntax_validator_top.sv
// JSON syntax validator, one byte per transaction.
//
// Input channel (s_*): one document byte per transaction in s_tdata, with
// s_tlast high on the final byte of the document. Output channel (m_*): one
// result per input byte, carrying the verdict (in progress, accepted at the
// final byte, rejected) and the number of containers open after that byte.
// The configuration port sets max_depth, the greatest number of objects and
// arrays open at once; write it only between documents.
//
// Each result follows its byte in the next cycle. Unless stalled, a byte is
// accepted in every cycle: the whole grammar step (one state transition and
// at most one push or pop on the container stack) is a single combinational
// pass from the state registers into the result register.
// The container stack is a shift register with its top at bit 0.
//
// Reset (aresetn low, synchronous) returns the parser to the top level,
// empties the stack and sets max_depth to 64. After the final byte of every
// document the parser returns to the same state. When the receiver stalls,
// the result register holds and s_tready drops until the result is taken.
module json_syntax_validator_top #(
    parameter int DEPTH_MAX = 64,
    parameter int KEY_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,    // max_depth
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] text_byte
    input  logic        s_tlast,        // final_byte
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata         // [1:0] verdict, [8:2] open_level, rest zero
);
    import jsv_pkg::*;

    localparam int LVL_W = $clog2(DEPTH_MAX + 1);
    localparam int CMP_W = (LVL_W > 7) ? LVL_W : 7;
    localparam int KL_W  = $clog2(KEY_BYTES);

    // Control state
    logic [6:0]       max_depth_reg;
    gstate_t          gstate_reg, gstate_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [2:0]       prog_reg, prog_next;
    logic [KL_W-1:0]  klen_reg, klen_next;
    logic             fail_reg, fail_next;
    logic             m_tvalid_reg;

    // Container stack, top entry at index 0
    logic [DEPTH_MAX-1:0] stack_reg, stack_next;

    // Result payload
    verdict_t         verdict_reg, verdict_next;
    logic [6:0]       open_level_reg, open_level_next;

    logic       s_accept;
    logic [7:0] c;
    logic       top_kind;
    logic       depth_full;
    logic       push_en, push_kind, pop_en;
    logic       do_begin, do_after, do_key;
    logic       complete;

    assign c        = s_tdata;
    assign top_kind = stack_reg[0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, open_level_reg, verdict_reg};

    assign depth_full = (CMP_W'(level_reg) >= CMP_W'(max_depth_reg)) ||
                        (level_reg >= LVL_W'(DEPTH_MAX));

    // One grammar step for the byte on s_tdata
    always_comb begin
        gstate_next = gstate_reg;
        level_next  = level_reg;
        prog_next   = prog_reg;
        klen_next   = klen_reg;
        fail_next   = fail_reg;
        push_en     = 1'b0;
        push_kind   = KIND_ARRAY;
        pop_en      = 1'b0;
        do_begin    = 1'b0;
        do_after    = 1'b0;
        do_key      = 1'b0;

        if (!fail_reg) begin
            unique case (gstate_reg)
                G_TOP, G_VALUE: begin
                    if (!is_ws(c)) do_begin = 1'b1;
                end
                G_ARR_FIRST: begin
                    if (c == CH_RBRACK) begin
                        pop_en      = 1'b1;
                        gstate_next = G_AFTER;
                    end else if (!is_ws(c)) begin
                        do_begin = 1'b1;
                    end
                end
                G_OBJ_FIRST, G_OBJ_KEY: begin
                    if (is_ws(c)) begin
                        gstate_next = gstate_reg;
                    end else if (c == CH_RBRACE && gstate_reg == G_OBJ_FIRST) begin
                        pop_en      = 1'b1;
                        gstate_next = G_AFTER;
                    end else if (c == CH_QUOTE) begin
                        klen_next   = '0;
                        gstate_next = G_KEY;
                    end else begin
                        fail_next = 1'b1;
                    end
                end
                G_COLON: begin
                    if (c == CH_COLON) gstate_next = G_VALUE;
                    else if (!is_ws(c)) fail_next = 1'b1;
                end
                G_AFTER: do_after = 1'b1;
                G_STR, G_KEY: begin
                    if (c == CH_QUOTE) begin
                        gstate_next = (gstate_reg == G_KEY) ? G_COLON : G_AFTER;
                    end else if (c < CH_SPACE) begin
                        fail_next = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        gstate_next = (gstate_reg == G_KEY) ? G_KEY_ESC : G_STR_ESC;
                    end else if (gstate_reg == G_KEY) begin
                        do_key = 1'b1;
                    end
                end
                G_STR_ESC, G_KEY_ESC: begin
                    if (c == "u") begin
                        prog_next   = '0;
                        gstate_next = (gstate_reg == G_KEY_ESC) ? G_KEY_HEX : G_STR_HEX;
                    end else if (is_simple_escape(c)) begin
                        gstate_next = (gstate_reg == G_KEY_ESC) ? G_KEY : G_STR;
                        do_key      = (gstate_reg == G_KEY_ESC);
                    end else begin
                        fail_next = 1'b1;
                    end
                end
                G_STR_HEX, G_KEY_HEX: begin
                    if (!is_hex(c)) begin
                        fail_next = 1'b1;
                    end else if (prog_reg + 3'd1 >= HEX_DIGITS) begin
                        prog_next   = '0;
                        gstate_next = (gstate_reg == G_KEY_HEX) ? G_KEY : G_STR;
                        do_key      = (gstate_reg == G_KEY_HEX);
                    end else begin
                        prog_next = prog_reg + 3'd1;
                    end
                end
                G_LIT_T, G_LIT_F, G_LIT_N: begin
                    if (prog_reg >= lit_len(gstate_reg) ||
                        c != lit_char(gstate_reg, prog_reg)) begin
                        fail_next = 1'b1;
                    end else begin
                        prog_next = prog_reg + 3'd1;
                        if (prog_reg + 3'd1 == lit_len(gstate_reg)) gstate_next = G_AFTER;
                    end
                end
                G_NUM_MINUS: begin
                    if (c == CH_ZERO) gstate_next = G_NUM_ZERO;
                    else if (is_digit(c)) gstate_next = G_NUM_INT;
                    else fail_next = 1'b1;
                end
                G_NUM_ZERO, G_NUM_INT: begin
                    if (is_digit(c) && gstate_reg == G_NUM_INT) gstate_next = G_NUM_INT;
                    else if (c == CH_DOT) gstate_next = G_NUM_DOT;
                    else if (c == "e" || c == "E") gstate_next = G_NUM_E;
                    else do_after = 1'b1;
                end
                G_NUM_DOT: begin
                    if (is_digit(c)) gstate_next = G_NUM_FRAC;
                    else fail_next = 1'b1;
                end
                G_NUM_FRAC: begin
                    if (is_digit(c)) gstate_next = G_NUM_FRAC;
                    else if (c == "e" || c == "E") gstate_next = G_NUM_E;
                    else do_after = 1'b1;
                end
                G_NUM_E: begin
                    if (c == CH_PLUS || c == CH_MINUS) gstate_next = G_NUM_ESIGN;
                    else if (is_digit(c)) gstate_next = G_NUM_EXP;
                    else fail_next = 1'b1;
                end
                G_NUM_ESIGN: begin
                    if (is_digit(c)) gstate_next = G_NUM_EXP;
                    else fail_next = 1'b1;
                end
                G_NUM_EXP: begin
                    if (!is_digit(c)) do_after = 1'b1;
                end
                default: fail_next = 1'b1;
            endcase
        end

        // Start of a value: scalar states, or a push of a new container
        if (do_begin) begin
            prog_next = 3'd1;
            if (c == CH_LBRACE || c == CH_LBRACK) begin
                if (depth_full) begin
                    fail_next = 1'b1;
                end else begin
                    push_en     = 1'b1;
                    push_kind   = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
                    gstate_next = (c == CH_LBRACE) ? G_OBJ_FIRST : G_ARR_FIRST;
                end
            end else if (c == CH_QUOTE) gstate_next = G_STR;
            else if (c == "t") gstate_next = G_LIT_T;
            else if (c == "f") gstate_next = G_LIT_F;
            else if (c == "n") gstate_next = G_LIT_N;
            else if (c == CH_MINUS) gstate_next = G_NUM_MINUS;
            else if (c == CH_ZERO) gstate_next = G_NUM_ZERO;
            else if (is_digit(c)) gstate_next = G_NUM_INT;
            else fail_next = 1'b1;
        end

        // Byte after a complete value: separator, close or whitespace
        if (do_after) begin
            gstate_next = G_AFTER;
            if (!is_ws(c)) begin
                if (level_reg == '0) begin
                    fail_next = 1'b1;
                end else if (c == CH_COMMA) begin
                    gstate_next = (top_kind == KIND_OBJECT) ? G_OBJ_KEY : G_VALUE;
                end else if ((c == CH_RBRACK && top_kind == KIND_ARRAY) ||
                             (c == CH_RBRACE && top_kind == KIND_OBJECT)) begin
                    pop_en = 1'b1;
                end else begin
                    fail_next = 1'b1;
                end
            end
        end

        // Count one decoded key byte; reject the one that reaches the limit
        if (do_key) begin
            if ({1'b0, klen_reg} + (KL_W+1)'(1) >= (KL_W+1)'(KEY_BYTES)) fail_next = 1'b1;
            else klen_next = klen_reg + KL_W'(1);
        end

        if (push_en) level_next = level_reg + LVL_W'(1);
        else if (pop_en) level_next = level_reg - LVL_W'(1);

        // Shift the stack by one place on push or pop
        stack_next = stack_reg;
        if (push_en) begin
            stack_next[0] = push_kind;
            for (int i = 1; i < DEPTH_MAX; i++) stack_next[i] = stack_reg[i-1];
        end else if (pop_en) begin
            for (int i = 0; i < DEPTH_MAX - 1; i++) stack_next[i] = stack_reg[i+1];
        end

        complete = (level_next == '0) &&
                   (gstate_next == G_AFTER || gstate_next == G_NUM_ZERO ||
                    gstate_next == G_NUM_INT || gstate_next == G_NUM_FRAC ||
                    gstate_next == G_NUM_EXP);

        if (fail_next) verdict_next = VERDICT_REJECT;
        else if (s_tlast) verdict_next = complete ? VERDICT_ACCEPT : VERDICT_REJECT;
        else verdict_next = VERDICT_BUSY;

        open_level_next = 7'(level_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= MAX_DEPTH_RESET;
            gstate_reg    <= G_TOP;
            level_reg     <= '0;
            prog_reg      <= '0;
            klen_reg      <= '0;
            fail_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) max_depth_reg <= cfg_wr_data;
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
                // Return to the top level after the final byte of a document
                if (s_tlast) begin
                    gstate_reg <= G_TOP;
                    level_reg  <= '0;
                    prog_reg   <= '0;
                    klen_reg   <= '0;
                    fail_reg   <= 1'b0;
                end else begin
                    gstate_reg <= gstate_next;
                    level_reg  <= level_next;
                    prog_reg   <= prog_next;
                    klen_reg   <= klen_next;
                    fail_reg   <= fail_next;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: stack contents and the result register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stack_reg      <= stack_next;
            verdict_reg    <= verdict_next;
            open_level_reg <= open_level_next;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(DEPTH_MAX))
        else $error("nesting level beyond stack depth");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> gstate_reg == G_TOP && level_reg == '0 && !fail_reg)
        else $error("parser not back at top level after final byte");

    a_fail_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && fail_reg |=> m_tvalid_reg && verdict_reg == VERDICT_REJECT)
        else $error("byte after an error not reported as rejected");

    a_hex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gstate_reg == G_STR_HEX || gstate_reg == G_KEY_HEX) |-> prog_reg < HEX_DIGITS)
        else $error("hex digit count out of range");

    a_level_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tlast |=> 7'(level_reg) == open_level_reg)
        else $error("reported level differs from parser level");

endmodule
